/* hdl/sound_voice_oscillator_core_assert.svh */
// Assertion macros for the voice oscillator core.
// Used by sound_voice_oscillator_core.sv; expects clk and rst_n in scope.
`ifndef SOUND_VOICE_OSCILLATOR_CORE_ASSERT_SVH
`define SOUND_VOICE_OSCILLATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SVO_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SVO_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/svo_pkg.sv */
// Shared types, constants and helper functions of the voice oscillator.
// No dependencies; imported by the interfaces and the core.
package svo_pkg;

    localparam int SVO_MAX_NOISE_SHIFTS_DEF = 16;

    localparam int PHASE_W      = 12;
    localparam int FRAC_W       = 16;
    localparam int STEP_WHOLE_W = 13;
    localparam int PULSE_W      = 12;
    localparam int NSTEP_W      = 24;
    localparam int CODE_W       = 4;
    localparam int ACC_W        = 22;
    localparam int LFSR_W       = 23;
    localparam int SAMPLE_W     = 8;
    localparam int APB_ADDR_W   = 5;
    localparam int APB_DATA_W   = 32;

    localparam logic [LFSR_W-1:0] NOISE_SEED = 23'h7ffff8;

    // Waveform codes; codes at or above WAVE_LOCK_MIN lock the noise.
    localparam logic [CODE_W-1:0] WAVE_SILENT   = 4'd0;
    localparam logic [CODE_W-1:0] WAVE_TRI      = 4'd1;
    localparam logic [CODE_W-1:0] WAVE_SAW      = 4'd2;
    localparam logic [CODE_W-1:0] WAVE_PULSE    = 4'd4;
    localparam logic [CODE_W-1:0] WAVE_NOISE    = 4'd8;
    localparam logic [CODE_W-1:0] WAVE_LOCK_MIN = 4'd9;

    // Input operations.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_TEST = 1'b1;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_STEP_WHOLE = 3'd0,
        REG_STEP_FRAC  = 3'd1,
        REG_PULSE      = 3'd2,
        REG_NOISE_STEP = 3'd3,
        REG_WAVE_CODE  = 3'd4,
        REG_RING       = 3'd5,
        REG_SPARE6     = 3'd6,
        REG_SPARE7     = 3'd7
    } svo_reg_t;

    // One clock of the noise LFSR: feedback is bit 22 xor bit 17.
    function automatic logic [LFSR_W-1:0] lfsr_clock(input logic [LFSR_W-1:0] r);
        return {r[LFSR_W-2:0], r[22] ^ r[17]};
    endfunction

    // Noise byte picked from eight LFSR bits, bit 22 as the MSB.
    function automatic logic [SAMPLE_W-1:0] noise_byte(input logic [LFSR_W-1:0] r);
        return {r[22], r[20], r[16], r[13], r[11], r[7], r[4], r[2]};
    endfunction

    // Triangle from phase: rising on the lower half, falling on the upper.
    function automatic logic [SAMPLE_W-1:0] tri_value(input logic [PHASE_W-1:0] p);
        return p[11] ? ~p[10:3] : p[10:3];
    endfunction

endpackage

/* hdl/svo_in_if.sv */
// Input channel of the voice oscillator: valid/ready plus one input item.
// Depends on svo_pkg for field widths.
interface svo_in_if
    import svo_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic signed [SAMPLE_W-1:0] prev_sample;
    logic                       modulator_phase_high;

    modport source (output valid, output op, output prev_sample,
                    output modulator_phase_high, input ready);
    modport sink   (input valid, input op, input prev_sample,
                    input modulator_phase_high, output ready);
endinterface

/* hdl/svo_out_if.sv */
// Result channel of the voice oscillator: valid/ready plus one result item.
// Depends on svo_pkg for field widths.
interface svo_out_if
    import svo_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] wave_out;
    logic [PHASE_W-1:0]  phase_now;
    logic                noise_locked;

    modport source (output valid, output wave_out, output phase_now,
                    output noise_locked, input ready);
    modport sink   (input valid, input wave_out, input phase_now,
                    input noise_locked, output ready);
endinterface

/* hdl/sound_voice_oscillator_core.sv */
// Voice oscillator core: waveform generation, phase step and LFSR noise.
// Depends on svo_pkg, svo_in_if, svo_out_if and sound_voice_oscillator_core_assert.svh.
//
// Usage:
//   sample_in carries one item per transfer: op (tick or test event), the
//   voice's previous sample and the modulator's phase MSB. result_out returns
//   exactly one item per input: wave_out, phase_now and noise_locked. The user must
//   write registers over the APB port only while the block is idle (not enforced).
// Timing:
//   A transfer on sample_in is followed by one noise LFSR shift per cycle, n in
//   all, and then the load of the result register, which waits while the
//   result output is stalled. n is 0 or 1 for a slow noise step and up to
//   MAX_NOISE_SHIFTS for a fast one. The single LFSR shifter, clocked once per
//   cycle, does the shifts. sample_in is ready only when the sequencer is idle.
// Reset and stall:
//   rst_n clears all registers, phase, accumulator and lock flag, and seeds
//   the LFSR. A stalled result waits in the output register; the next input
//   item is still taken, and its result is held back until that one leaves.
module sound_voice_oscillator_core
    import svo_pkg::*;
#(
    parameter int MAX_NOISE_SHIFTS = SVO_MAX_NOISE_SHIFTS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    svo_in_if.sink                sample_in,
    svo_out_if.source             result_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(MAX_NOISE_SHIFTS + 1);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;
    localparam logic [CMP_W-1:0] SHIFT_CAP = CMP_W'(MAX_NOISE_SHIFTS - 1);

    typedef enum logic {
        ST_IDLE,
        ST_SHIFT
    } state_t;

    // Configuration registers.
    logic [STEP_WHOLE_W-1:0] step_whole_reg;
    logic [FRAC_W-1:0]       step_frac_reg;
    logic [PULSE_W-1:0]      pulse_width_reg;
    logic [NSTEP_W-1:0]      noise_step_reg;
    logic [CODE_W-1:0]       wave_code_reg;
    logic                    ring_enable_reg;

    // Oscillator state and sequencer.
    state_t              state_reg;
    logic [PHASE_W-1:0]  phase_reg;
    logic [FRAC_W-1:0]   frac_reg;
    logic [ACC_W-1:0]    noise_acc_reg;
    logic [LFSR_W-1:0]   noise_shift_reg;
    logic [SAMPLE_W-1:0] noise_value_reg;
    logic                lock_flag_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                refresh_reg;
    logic [SAMPLE_W-1:0] wave_reg;

    // Result register.
    logic                out_valid_reg;
    logic [SAMPLE_W-1:0] out_wave_reg;
    logic [PHASE_W-1:0]  out_phase_reg;
    logic                out_locked_reg;

    logic                cfg_write;
    svo_reg_t            cfg_sel;
    logic                in_xfer;
    logic                out_free;
    logic                load_out;
    logic                is_lock;
    logic                is_noise;
    logic [FRAC_W:0]     frac_sum;
    logic [PHASE_W-1:0]  phase_next;
    logic [FRAC_W-1:0]   frac_next;
    logic [SAMPLE_W-1:0] prev_flip;
    logic [SAMPLE_W-1:0] wave_next;
    logic                multi_mode;
    logic [20:0]         acc_addend;
    logic [ACC_W:0]      acc_sum;
    logic                acc_carry;
    logic [ACC_W:0]      acc_less;
    logic [ACC_W-1:0]    acc_next;
    logic [CMP_W-1:0]    step_hi;
    logic [CMP_W-1:0]    shifts_sel;
    logic [CNT_W-1:0]    cnt_next;

    // APB write decode and read mux.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_sel   = svo_reg_t'(paddr[4:2]);

    always_comb
    begin
        unique case (cfg_sel)
            REG_STEP_WHOLE: prdata = APB_DATA_W'(step_whole_reg);
            REG_STEP_FRAC:  prdata = APB_DATA_W'(step_frac_reg);
            REG_PULSE:      prdata = APB_DATA_W'(pulse_width_reg);
            REG_NOISE_STEP: prdata = APB_DATA_W'(noise_step_reg);
            REG_WAVE_CODE:  prdata = APB_DATA_W'(wave_code_reg);
            REG_RING:       prdata = APB_DATA_W'(ring_enable_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_whole_reg  <= '0;
            step_frac_reg   <= '0;
            pulse_width_reg <= '0;
            noise_step_reg  <= '0;
            wave_code_reg   <= '0;
            ring_enable_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_sel)
                REG_STEP_WHOLE: step_whole_reg  <= pwdata[STEP_WHOLE_W-1:0];
                REG_STEP_FRAC:  step_frac_reg   <= pwdata[FRAC_W-1:0];
                REG_PULSE:      pulse_width_reg <= pwdata[PULSE_W-1:0];
                REG_NOISE_STEP: noise_step_reg  <= pwdata[NSTEP_W-1:0];
                REG_WAVE_CODE:  wave_code_reg   <= pwdata[CODE_W-1:0];
                REG_RING:       ring_enable_reg <= pwdata[0];
                default:        ;
            endcase
        end
    end

    // Handshake: take an item whenever the sequencer is idle.
    assign sample_in.ready = (state_reg == ST_IDLE);
    assign in_xfer         = sample_in.valid && sample_in.ready;
    assign out_free        = !out_valid_reg || result_out.ready;
    assign load_out        = (state_reg == ST_SHIFT) && (cnt_reg == '0) && out_free;

    assign result_out.valid        = out_valid_reg;
    assign result_out.wave_out     = out_wave_reg;
    assign result_out.phase_now    = out_phase_reg;
    assign result_out.noise_locked = out_locked_reg;

    // Phase step: fraction first, its carry into the whole part.
    assign frac_sum   = {1'b0, frac_reg} + {1'b0, step_frac_reg};
    assign frac_next  = frac_sum[FRAC_W-1:0];
    assign phase_next = phase_reg + step_whole_reg[PHASE_W-1:0]
                        + PHASE_W'(frac_sum[FRAC_W]);

    // Waveform value from the current phase, the noise byte or the previous sample.
    assign is_lock   = (wave_code_reg >= WAVE_LOCK_MIN);
    assign is_noise  = (wave_code_reg == WAVE_NOISE);
    assign prev_flip = {~sample_in.prev_sample[7], sample_in.prev_sample[6:0]};

    always_comb
    begin
        priority if (is_lock)
            wave_next = prev_flip;
        else if (is_noise)
            wave_next = noise_value_reg;
        else if (wave_code_reg == WAVE_TRI)
            wave_next = tri_value(phase_reg)
                        ^ {SAMPLE_W{ring_enable_reg && sample_in.modulator_phase_high}};
        else if (wave_code_reg == WAVE_SAW)
            wave_next = phase_reg[11:4];
        else if (wave_code_reg == WAVE_PULSE)
            wave_next = (phase_reg < pulse_width_reg) ? 8'hFF : 8'h00;
        else
            wave_next = prev_flip;
    end

    // Noise accumulator and the number of LFSR shifts for this tick.
    assign multi_mode = |noise_step_reg[23:21];
    assign acc_addend = multi_mode ? {1'b0, noise_step_reg[19:0]} : noise_step_reg[20:0];
    assign acc_sum    = {1'b0, noise_acc_reg} + (ACC_W + 1)'(acc_addend);
    assign acc_carry  = |acc_sum[ACC_W:20];
    assign acc_less   = acc_sum - (ACC_W + 1)'(1 << 20);
    assign acc_next   = acc_carry ? acc_less[ACC_W-1:0] : acc_sum[ACC_W-1:0];
    assign step_hi    = CMP_W'(noise_step_reg[23:20]);
    assign shifts_sel = !multi_mode ? '0 : ((step_hi > SHIFT_CAP) ? SHIFT_CAP : step_hi);
    assign cnt_next   = CNT_W'(shifts_sel) + CNT_W'(acc_carry);

    // Sequencer: one item step, then one LFSR shift per cycle, then the result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= '0;
            frac_reg        <= '0;
            noise_acc_reg   <= '0;
            noise_shift_reg <= NOISE_SEED;
            noise_value_reg <= '0;
            lock_flag_reg   <= 1'b0;
            cnt_reg         <= '0;
            refresh_reg     <= 1'b0;
            wave_reg        <= '0;
            out_valid_reg   <= 1'b0;
            out_wave_reg    <= '0;
            out_phase_reg   <= '0;
            out_locked_reg  <= 1'b0;
        end
        else
        begin
            // The result register fills on a load and drains on a transfer.
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg   <= ST_SHIFT;
                        cnt_reg     <= '0;
                        refresh_reg <= 1'b0;
                        wave_reg    <= '0;
                        if (sample_in.op == OP_TEST)
                        begin
                            if (lock_flag_reg)
                            begin
                                lock_flag_reg   <= 1'b0;
                                noise_shift_reg <= NOISE_SEED;
                            end
                        end
                        else
                        begin
                            wave_reg  <= wave_next;
                            phase_reg <= phase_next;
                            frac_reg  <= frac_next;
                            if (is_lock)
                            begin
                                lock_flag_reg <= 1'b1;
                            end
                            if (is_noise)
                            begin
                                noise_acc_reg <= acc_next;
                                cnt_reg       <= cnt_next;
                                refresh_reg   <= multi_mode || acc_carry;
                            end
                        end
                    end
                end
                ST_SHIFT:
                begin
                    if (cnt_reg != '0)
                    begin
                        noise_shift_reg <= lfsr_clock(noise_shift_reg);
                        cnt_reg         <= cnt_reg - CNT_W'(1);
                    end
                    else if (out_free)
                    begin
                        state_reg      <= ST_IDLE;
                        out_wave_reg   <= wave_reg;
                        out_phase_reg  <= phase_reg;
                        out_locked_reg <= lock_flag_reg;
                        if (refresh_reg)
                        begin
                            noise_value_reg <= noise_byte(noise_shift_reg);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "sound_voice_oscillator_core_assert.svh"

    // Every accepted item starts the shift phase of the sequencer.
    `SVO_ASSERT_NEXT(a_accept_to_shift, in_xfer, state_reg == ST_SHIFT, "accept did not start the sequencer")
    // The shift count never runs past the configured bound.
    `SVO_ASSERT_SAME(a_cnt_bound, state_reg == ST_SHIFT, cnt_reg <= CNT_W'(MAX_NOISE_SHIFTS), "shift count out of range")
    // A pending shift clocks the LFSR exactly once.
    `SVO_ASSERT_NEXT(a_lfsr_step, (state_reg == ST_SHIFT) && (cnt_reg != '0), noise_shift_reg == lfsr_clock($past(noise_shift_reg)), "LFSR did not shift")
    // The LFSR never falls into the all-zero lockup state.
    `SVO_ASSERT_SAME(a_lfsr_nonzero, 1'b1, noise_shift_reg != '0, "LFSR reached zero")

endmodule

/* bench/sound_voice_oscillator_core_tb.sv */
// Self-checking testbench for sound_voice_oscillator_core: directed and random sample ticks
// and test events, with registers set over APB and every result checked against a predictor.
// Depends on svo_pkg, svo_in_if, svo_out_if and the core itself.
module sound_voice_oscillator_core_tb
    import svo_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NOISE_ACC_UNIT  = 32'd1 << 20;
    localparam int unsigned NOISE_FAST_MIN  = 32'd1 << 21;
    localparam int unsigned NOISE_SHIFT_CAP = SVO_MAX_NOISE_SHIFTS_DEF - 1;
    localparam int          STALL_LIMIT     = 3000;
    localparam int          SWEEP_PHASES    = 24;
    localparam int          ITEMS_PER_PHASE = 30;

    typedef struct packed {
        logic [SAMPLE_W-1:0] wave;
        logic [PHASE_W-1:0]  phase;
        logic                locked;
    } voice_result_t;

    logic clk;
    logic rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    svo_in_if  sample_ch ();
    svo_out_if result_ch ();

    sound_voice_oscillator_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_ch),
        .result_out (result_ch),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // Register copies and oscillator state held by the predictor.
    logic [STEP_WHOLE_W-1:0] cfg_step_whole;
    logic [FRAC_W-1:0]       cfg_step_frac;
    logic [PULSE_W-1:0]      cfg_pulse_width;
    logic [NSTEP_W-1:0]      cfg_noise_step;
    logic [CODE_W-1:0]       cfg_wave_code;
    logic                    cfg_ring;
    logic [PHASE_W-1:0]      osc_phase;
    logic [FRAC_W-1:0]       osc_frac;
    logic [ACC_W-1:0]        noise_acc_q;
    logic [LFSR_W-1:0]       noise_lfsr;
    logic [SAMPLE_W-1:0]     noise_sample;
    logic                    noise_lock;

    voice_result_t pending_samples[$];

    int  mismatch_count;
    int  tick_count;
    int  test_event_count;
    int  reg_write_count;
    int  checked_count;
    int  idle_cycles = 0;
    bit  idle_enabled;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Noise LFSR: one shift, feedback from bits 22 and 17 into bit 0.
    function automatic void shift_noise_lfsr();
        noise_lfsr = {noise_lfsr[LFSR_W-2:0], noise_lfsr[22] ^ noise_lfsr[17]};
    endfunction

    function automatic logic [SAMPLE_W-1:0] noise_tap_byte(logic [LFSR_W-1:0] r);
        logic [SAMPLE_W-1:0] b;
        b[7] = r[22];
        b[6] = r[20];
        b[5] = r[16];
        b[4] = r[13];
        b[3] = r[11];
        b[2] = r[7];
        b[1] = r[4];
        b[0] = r[2];
        return b;
    endfunction

    function automatic void advance_phase();
        logic [FRAC_W:0] frac_sum;
        logic [13:0]     whole_sum;
        frac_sum  = {1'b0, osc_frac} + {1'b0, cfg_step_frac};
        whole_sum = {2'b00, osc_phase} + {1'b0, cfg_step_whole} + frac_sum[FRAC_W];
        osc_frac  = frac_sum[FRAC_W-1:0];
        osc_phase = whole_sum[PHASE_W-1:0];
    endfunction

    // Noise clocking: a burst of shifts for a fast step, otherwise at most one per tick.
    function automatic void advance_noise();
        int unsigned acc;
        int unsigned burst;
        acc = noise_acc_q;
        if (cfg_noise_step >= NOISE_FAST_MIN)
        begin
            burst = cfg_noise_step >> 20;
            if (burst > NOISE_SHIFT_CAP)
                burst = NOISE_SHIFT_CAP;
            repeat (burst) shift_noise_lfsr();
            acc += cfg_noise_step & (NOISE_ACC_UNIT - 1);
            if (acc >= NOISE_ACC_UNIT)
            begin
                acc -= NOISE_ACC_UNIT;
                shift_noise_lfsr();
            end
            noise_sample = noise_tap_byte(noise_lfsr);
        end
        else
        begin
            acc += cfg_noise_step;
            if (acc >= NOISE_ACC_UNIT)
            begin
                acc -= NOISE_ACC_UNIT;
                shift_noise_lfsr();
                noise_sample = noise_tap_byte(noise_lfsr);
            end
        end
        noise_acc_q = acc[ACC_W-1:0];
    endfunction

    // Works out the result of one input item and moves the predictor state on.
    function automatic voice_result_t next_voice_sample(logic op, logic [SAMPLE_W-1:0] prev,
                                                        logic mod_high);
        voice_result_t r;
        int            tri_level;
        r.wave = '0;
        if (op == OP_TEST)
        begin
            if (noise_lock)
            begin
                noise_lock = 1'b0;
                noise_lfsr = NOISE_SEED;
            end
        end
        else
        begin
            if (cfg_wave_code >= WAVE_LOCK_MIN)
            begin
                noise_lock = 1'b1;
                r.wave     = prev - 8'h80;
            end
            else if (cfg_wave_code == WAVE_NOISE)
                r.wave = noise_sample;
            else if (cfg_wave_code == WAVE_TRI)
            begin
                if (osc_phase < 2048)
                    tri_level = osc_phase >> 3;
                else
                    tri_level = 255 - ((osc_phase - 2048) >> 3);
                r.wave = tri_level[SAMPLE_W-1:0];
                if (cfg_ring && mod_high)
                    r.wave = r.wave ^ 8'hFF;
            end
            else if (cfg_wave_code == WAVE_SAW)
                r.wave = osc_phase[PHASE_W-1:4];
            else if (cfg_wave_code == WAVE_PULSE)
                r.wave = (osc_phase < cfg_pulse_width) ? 8'hFF : 8'h00;
            else
                r.wave = prev - 8'h80;
            advance_phase();
            if (cfg_wave_code == WAVE_NOISE)
                advance_noise();
        end
        r.phase  = osc_phase;
        r.locked = noise_lock;
        return r;
    endfunction

    function automatic void reset_predictor();
        cfg_step_whole  = '0;
        cfg_step_frac   = '0;
        cfg_pulse_width = '0;
        cfg_noise_step  = '0;
        cfg_wave_code   = WAVE_SILENT;
        cfg_ring        = 1'b0;
        osc_phase       = '0;
        osc_frac        = '0;
        noise_acc_q     = '0;
        noise_lfsr      = NOISE_SEED;
        noise_sample    = '0;
        noise_lock      = 1'b0;
    endfunction

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $realtime, what);
    endtask

    // Random gap or stall length: mostly short, now and then long.
    function automatic int pick_idle_length();
        int r;
        if (!idle_enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // APB write: setup cycle, then access cycle; the predictor copy follows.
    task automatic write_reg(svo_reg_t idx, logic [APB_DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        case (idx)
            REG_STEP_WHOLE: cfg_step_whole  = value[STEP_WHOLE_W-1:0];
            REG_STEP_FRAC:  cfg_step_frac   = value[FRAC_W-1:0];
            REG_PULSE:      cfg_pulse_width = value[PULSE_W-1:0];
            REG_NOISE_STEP: cfg_noise_step  = value[NSTEP_W-1:0];
            REG_WAVE_CODE:  cfg_wave_code   = value[CODE_W-1:0];
            REG_RING:       cfg_ring        = value[0];
            default: ;
        endcase
        reg_write_count++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Sends one item; valid stays high afterwards so back-to-back transfers need no gap.
    task automatic send_item(logic op, logic [SAMPLE_W-1:0] prev, logic mod_high);
        int gap;
        gap = pick_idle_length();
        if (gap > 0)
        begin
            @(negedge clk);
            sample_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_ch.valid                <= 1'b1;
        sample_ch.op                   <= op;
        sample_ch.prev_sample          <= prev;
        sample_ch.modulator_phase_high <= mod_high;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_samples.push_back(next_voice_sample(op, prev, mod_high));
        if (op == OP_TEST)
            test_event_count++;
        else
            tick_count++;
    endtask

    task automatic send_random_item();
        logic op;
        op = ($urandom_range(0, 9) == 0) ? OP_TEST : OP_TICK;
        send_item(op, 8'($urandom), 1'($urandom));
    endtask

    // Drops valid and waits until every outstanding result has been checked.
    task automatic wait_for_results();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_samples.size() != 0)
            @(posedge clk);
    endtask

    // Picks a new setting for the registers; extremes come up often.
    task automatic randomize_settings(bit write_all);
        logic [CODE_W-1:0] code_pool[14] = '{WAVE_SILENT, WAVE_TRI, WAVE_TRI, WAVE_SAW,
            WAVE_SAW, WAVE_PULSE, WAVE_PULSE, WAVE_NOISE, WAVE_NOISE, WAVE_NOISE,
            4'd3, 4'd5, 4'd6, 4'd7};
        logic [APB_DATA_W-1:0] v;
        int                    r;
        if (write_all || $urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 9);
            v = (r == 0) ? 0 : (r == 1) ? 4096 : (r == 2) ? 4095 :
                (r < 6) ? $urandom_range(0, 15) : $urandom_range(0, 4096);
            write_reg(REG_STEP_WHOLE, v);
        end
        if (write_all || $urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 5);
            v = (r == 0) ? 0 : (r == 1) ? 65535 : $urandom_range(0, 65535);
            write_reg(REG_STEP_FRAC, v);
        end
        if (write_all || $urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 5);
            v = (r == 0) ? 0 : (r == 1) ? 4095 : $urandom_range(0, 4095);
            write_reg(REG_PULSE, v);
        end
        if (write_all || $urandom_range(0, 2) != 0)
        begin
            r = $urandom_range(0, 11);
            case (r)
                0:       v = 0;
                1:       v = NOISE_FAST_MIN - 1;
                2:       v = NOISE_FAST_MIN;
                3:       v = 24'hFFFFFF;
                4, 5, 6: v = $urandom_range(0, NOISE_FAST_MIN - 1);
                default: v = $urandom_range(NOISE_FAST_MIN, 24'hFFFFFF);
            endcase
            write_reg(REG_NOISE_STEP, v);
        end
        if ($urandom_range(0, 99) < 25)
            write_reg(REG_WAVE_CODE, $urandom_range(WAVE_LOCK_MIN, 15));
        else
            write_reg(REG_WAVE_CODE, code_pool[$urandom_range(0, 13)]);
        if (write_all || $urandom_range(0, 1) != 0)
            write_reg(REG_RING, $urandom_range(0, 1));
    endtask

    // Silent codes straight after reset, then with a whole step of 4096 and the largest fraction step.
    task automatic test_silent_codes();
        send_item(OP_TICK, 8'h80, 1'b0);
        send_item(OP_TICK, 8'h7F, 1'b1);
        wait_for_results();
        write_reg(REG_STEP_WHOLE, 4096);
        write_reg(REG_STEP_FRAC, 65535);
        send_item(OP_TICK, 8'h00, 1'b0);
        send_item(OP_TICK, 8'hFF, 1'b1);
        send_item(OP_TEST, 8'h55, 1'b0);
        wait_for_results();
        for (int c = 3; c <= 7; c += 2)
        begin
            write_reg(REG_WAVE_CODE, c);
            send_item(OP_TICK, 8'($urandom), 1'($urandom));
            wait_for_results();
        end
    endtask

    // Triangle with and without ring modulation, sawtooth and pulse at its widths.
    task automatic test_basic_waveforms();
        write_reg(REG_STEP_WHOLE, 2047);
        write_reg(REG_STEP_FRAC, 16'h8000);
        write_reg(REG_WAVE_CODE, WAVE_TRI);
        write_reg(REG_RING, 1);
        send_item(OP_TICK, 8'h00, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b0);
        send_item(OP_TICK, 8'h00, 1'b1);
        wait_for_results();
        // Ring modulation does nothing outside the triangle.
        write_reg(REG_WAVE_CODE, WAVE_SAW);
        send_item(OP_TICK, 8'h00, 1'b1);
        send_item(OP_TICK, 8'h00, 1'b1);
        wait_for_results();
        write_reg(REG_RING, 0);
        write_reg(REG_WAVE_CODE, WAVE_PULSE);
        write_reg(REG_PULSE, 0);
        send_item(OP_TICK, 8'h00, 1'b0);
        wait_for_results();
        write_reg(REG_PULSE, 4095);
        send_item(OP_TICK, 8'h00, 1'b0);
        send_item(OP_TICK, 8'h00, 1'b0);
        wait_for_results();
    endtask

    // Noise in single and burst mode, then locking and the test event that clears it.
    task automatic test_noise_and_lock();
        write_reg(REG_WAVE_CODE, WAVE_NOISE);
        write_reg(REG_NOISE_STEP, NOISE_FAST_MIN - 1);
        send_item(OP_TICK, 8'h00, 1'b0);
        send_item(OP_TICK, 8'h00, 1'b0);
        wait_for_results();
        write_reg(REG_NOISE_STEP, 24'hFFFFFF);
        send_item(OP_TICK, 8'h00, 1'b0);
        send_item(OP_TICK, 8'h00, 1'b0);
        wait_for_results();
        write_reg(REG_NOISE_STEP, NOISE_FAST_MIN);
        send_item(OP_TICK, 8'h00, 1'b0);
        wait_for_results();
        write_reg(REG_WAVE_CODE, 15);
        send_item(OP_TICK, 8'h80, 1'b0);
        wait_for_results();
        // A lock code keeps its behavior even with ring modulation on.
        write_reg(REG_RING, 1);
        write_reg(REG_WAVE_CODE, WAVE_LOCK_MIN);
        send_item(OP_TICK, 8'h7F, 1'b1);
        send_item(OP_TEST, 8'h00, 1'b0);
        send_item(OP_TEST, 8'h00, 1'b1);
        wait_for_results();
        write_reg(REG_RING, 0);
        write_reg(REG_WAVE_CODE, WAVE_NOISE);
        send_item(OP_TICK, 8'h00, 1'b0);
        wait_for_results();
    endtask

    // Sender holds off after each item until its result is back.
    task automatic test_sender_waits_for_results();
        write_reg(REG_WAVE_CODE, WAVE_NOISE);
        write_reg(REG_NOISE_STEP, $urandom_range(NOISE_FAST_MIN, 24'hFFFFFF));
        for (int i = 0; i < 20; i++)
        begin
            send_random_item();
            wait_for_results();
        end
    endtask

    // Random settings, each followed by a run of random items; some runs without idling.
    task automatic test_random_sweep();
        for (int ph = 0; ph < SWEEP_PHASES; ph++)
        begin
            idle_enabled = (ph % 6 != 2);
            randomize_settings(ph == 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_random_item();
            wait_for_results();
        end
        idle_enabled = 1'b1;
    endtask

    // Result side: stalls of random length, held by a run counter.
    initial
    begin : result_ready_driver
        int  run_left;
        bit  level;
        run_left        = 0;
        level           = 1'b1;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run_left == 0)
            begin
                if (!idle_enabled)
                begin
                    level    = 1'b1;
                    run_left = 1;
                end
                else if (level)
                begin
                    run_left = pick_idle_length();
                    level    = (run_left == 0);
                    if (run_left == 0)
                        run_left = 1;
                end
                else
                begin
                    level    = 1'b1;
                    run_left = $urandom_range(1, 8);
                end
            end
            result_ch.ready <= level;
            run_left--;
        end
    end

    // Every result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin
        voice_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_samples.size() == 0)
                report_mismatch($sformatf("result with none outstanding: wave %0d phase %0d",
                                          result_ch.wave_out, result_ch.phase_now));
            else
            begin
                want = pending_samples.pop_front();
                checked_count++;
                if (result_ch.wave_out !== want.wave)
                    report_mismatch($sformatf("wave_out %0d, predicted %0d",
                                              result_ch.wave_out, want.wave));
                if (result_ch.phase_now !== want.phase)
                    report_mismatch($sformatf("phase_now %0d, predicted %0d",
                                              result_ch.phase_now, want.phase));
                if (result_ch.noise_locked !== want.locked)
                    report_mismatch($sformatf("noise_locked %0b, predicted %0b",
                                              result_ch.noise_locked, want.locked));
            end
        end
    end

    // Watchdog: counts cycles without any transfer or register write.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        while (idle_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Watchdog: no transfer for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
    end

    // Test sequence.
    initial
    begin
        rst_n                          = 1'b0;
        psel                           = 1'b0;
        penable                        = 1'b0;
        pwrite                         = 1'b0;
        paddr                          = '0;
        pwdata                         = '0;
        sample_ch.valid                = 1'b0;
        sample_ch.op                   = OP_TICK;
        sample_ch.prev_sample          = '0;
        sample_ch.modulator_phase_high = 1'b0;
        mismatch_count                 = 0;
        tick_count                     = 0;
        test_event_count               = 0;
        reg_write_count                = 0;
        checked_count                  = 0;
        idle_enabled                   = 1'b1;
        reset_predictor();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_silent_codes();
        test_basic_waveforms();
        test_noise_and_lock();
        test_sender_waits_for_results();
        test_random_sweep();

        // Let any stray result show up before the verdict.
        wait_for_results();
        idle_enabled = 1'b0;
        repeat (40) @(posedge clk);

        $display("Covered %0d sample ticks and %0d test events under %0d register writes;",
                 tick_count, test_event_count, reg_write_count);
        $display("%0d results compared, %0d mismatches.", checked_count, mismatch_count);
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hdl
hdl/svo_pkg.sv
hdl/svo_in_if.sv
hdl/svo_out_if.sv
hdl/sound_voice_oscillator_core.sv
bench/sound_voice_oscillator_core_tb.sv
